// ===== rtl/hrrn_pkg.sv =====
// Shared types and constants for the HRRN scheduler core.
// No dependencies; imported by hrrn_mul and hrrn_scheduler_core.
package hrrn_pkg;

  localparam int TIME_W = 16;               // arrival and burst fields
  localparam int TICK_W = 23;               // scheduler clock, completion tick
  localparam int SPAN_W = 22;               // turnaround and waiting time
  localparam int ID_W   = 7;                // reported job number
  localparam int PROD_W = TICK_W + TIME_W;  // ratio cross product

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_MUL2,
    ST_CMP,
    ST_DECIDE,
    ST_OUT
  } state_t;

  // operands for the shared cross-multiplier
  typedef struct packed {
    logic [TICK_W-1:0] ratio;
    logic [TIME_W-1:0] burst;
  } mul_op_t;

endpackage

// ===== rtl/hrrn_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module hrrn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/hrrn_mul.sv =====
// Shared cross-multiplier for response-ratio compares, registered output.
// Depends on hrrn_pkg.
module hrrn_mul
  import hrrn_pkg::*;
(
  input  logic              clk,
  input  mul_op_t           op,
  output logic [PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= PROD_W'(op.ratio) * PROD_W'(op.burst);
  end

endmodule

// ===== rtl/hrrn_scheduler_core.sv =====
// HRRN scheduler core: loads jobs one per cycle while idle, then emits them in run order.
// Load: one transaction per cycle; after the job marked last, in_stall stays high
// until the set's final result transaction. Each result reads and evaluates every
// stored entry (a compare on the shared multiplier adds the MUL2 and CMP states), then
// decides and outputs, after a jump to the next arrival if none has arrived.
// Reset (rst, synchronous) empties the job set and clears all control state.
module hrrn_scheduler_core
  import hrrn_pkg::*;
#(
  parameter int MAX_PROCS = 16
) (
  input  logic              clk,
  input  logic              rst,
  // job load channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [TIME_W-1:0] job_arrival,
  input  logic [TIME_W-1:0] job_burst,
  input  logic              last_job,
  // schedule result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ID_W-1:0]   job_id,
  output logic [TICK_W-1:0] finish_tick,
  output logic [SPAN_W-1:0] turnaround,
  output logic [SPAN_W-1:0] wait_ticks,
  output logic              last_result
);

  localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;  // entry index
  localparam int CW = $clog2(MAX_PROCS + 1);                    // job count

  state_t state, state_next;

  // control state
  logic [CW-1:0]        count, count_next;      // jobs stored
  logic [CW-1:0]        emitted, emitted_next;  // jobs scheduled so far
  logic [MAX_PROCS-1:0] done, done_next;
  logic [TICK_W-1:0]    now, now_next;
  logic [IW-1:0]        idx, idx_next;          // scan pointer, also RAM read address
  logic                 have_best, have_best_next;
  logic                 min_seen, min_seen_next;

  // scan payload
  logic [TIME_W-1:0]    best_arr, best_arr_next;
  logic [TIME_W-1:0]    best_bur, best_bur_next;
  logic [IW-1:0]        best_id, best_id_next;
  logic [TIME_W-1:0]    min_arr, min_arr_next;
  logic [PROD_W-1:0]    prod_a, prod_a_next;

  // result registers
  logic [ID_W-1:0]      job_id_next;
  logic [TICK_W-1:0]    finish_tick_next;
  logic [SPAN_W-1:0]    turnaround_next, wait_ticks_next;
  logic                 last_result_next;

  // job store: {arrival, burst} per entry
  logic                 st_we;
  logic [2*TIME_W-1:0]  st_wdata, st_rdata;
  logic [TIME_W-1:0]    cur_arr, cur_bur, load_bur;

  // compare path
  mul_op_t              mul_op;
  logic [PROD_W-1:0]    prod;
  logic [TICK_W-1:0]    ratio_cur, ratio_best, fin;
  logic                 cur_ready, cur_wins, last_idx, accept;

  assign accept   = in_valid && !in_stall;
  assign load_bur = (job_burst == '0) ? TIME_W'(1) : job_burst;  // zero burst runs as one
  assign st_we    = accept && (count < CW'(MAX_PROCS));         // full store drops the job
  assign st_wdata = {job_arrival, load_bur};

  hrrn_ram #(
    .WIDTH (2 * TIME_W),
    .DEPTH (MAX_PROCS)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (count[IW-1:0]),
    .wdata (st_wdata),
    .raddr (idx),
    .rdata (st_rdata)
  );

  assign cur_arr = st_rdata[2*TIME_W-1:TIME_W];
  assign cur_bur = st_rdata[TIME_W-1:0];

  // response ratio numerators: wait + burst
  assign ratio_cur  = now - TICK_W'(cur_arr) + TICK_W'(cur_bur);
  assign ratio_best = now - TICK_W'(best_arr) + TICK_W'(best_bur);

  // first pass: ratio_cur * best_bur, second pass: ratio_best * cur_bur
  assign mul_op.ratio = (state == ST_MUL2) ? ratio_best : ratio_cur;
  assign mul_op.burst = (state == ST_MUL2) ? cur_bur : best_bur;

  hrrn_mul u_mul (
    .clk  (clk),
    .op   (mul_op),
    .prod (prod)
  );

  assign cur_ready = !done[idx] && (TICK_W'(cur_arr) <= now);
  // strict win on ratio, then earlier arrival; equal arrival keeps the earlier entry
  assign cur_wins  = (prod_a > prod) || ((prod_a == prod) && (cur_arr < best_arr));
  assign last_idx  = (CW'(idx) + CW'(1)) == count;
  assign fin       = now + TICK_W'(best_bur);

  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      emitted   <= '0;
      done      <= '0;
      now       <= '0;
      idx       <= '0;
      have_best <= 1'b0;
      min_seen  <= 1'b0;
    end else begin
      count     <= count_next;
      emitted   <= emitted_next;
      done      <= done_next;
      now       <= now_next;
      idx       <= idx_next;
      have_best <= have_best_next;
      min_seen  <= min_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    best_arr    <= best_arr_next;
    best_bur    <= best_bur_next;
    best_id     <= best_id_next;
    min_arr     <= min_arr_next;
    prod_a      <= prod_a_next;
    job_id      <= job_id_next;
    finish_tick <= finish_tick_next;
    turnaround  <= turnaround_next;
    wait_ticks  <= wait_ticks_next;
    last_result <= last_result_next;
  end

  always_comb begin
    state_next       = state;
    count_next       = count;
    emitted_next     = emitted;
    done_next        = done;
    now_next         = now;
    idx_next         = idx;
    have_best_next   = have_best;
    min_seen_next    = min_seen;
    best_arr_next    = best_arr;
    best_bur_next    = best_bur;
    best_id_next     = best_id;
    min_arr_next     = min_arr;
    prod_a_next      = prod_a;
    job_id_next      = job_id;
    finish_tick_next = finish_tick;
    turnaround_next  = turnaround;
    wait_ticks_next  = wait_ticks;
    last_result_next = last_result;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (st_we) begin
            count_next = count + CW'(1);
          end
          if (last_job) begin
            idx_next       = '0;
            have_best_next = 1'b0;
            min_seen_next  = 1'b0;
            state_next     = ST_READ;
          end
        end
      end

      ST_READ: begin
        // RAM read of entry idx lands next cycle
        state_next = ST_EVAL;
      end

      ST_EVAL: begin
        if (!done[idx] && (!min_seen || cur_arr < min_arr)) begin
          min_arr_next  = cur_arr;
          min_seen_next = 1'b1;
        end
        if (cur_ready && have_best) begin
          state_next = ST_MUL2;   // first product launched this cycle
        end else begin
          if (cur_ready) begin
            best_arr_next  = cur_arr;
            best_bur_next  = cur_bur;
            best_id_next   = idx;
            have_best_next = 1'b1;
          end
          if (last_idx) begin
            state_next = ST_DECIDE;
          end else begin
            idx_next   = idx + IW'(1);
            state_next = ST_READ;
          end
        end
      end

      ST_MUL2: begin
        prod_a_next = prod;
        state_next  = ST_CMP;
      end

      ST_CMP: begin
        if (cur_wins) begin
          best_arr_next = cur_arr;
          best_bur_next = cur_bur;
          best_id_next  = idx;
        end
        if (last_idx) begin
          state_next = ST_DECIDE;
        end else begin
          idx_next   = idx + IW'(1);
          state_next = ST_READ;
        end
      end

      ST_DECIDE: begin
        if (have_best) begin
          done_next[best_id] = 1'b1;
          now_next           = fin;
          emitted_next       = emitted + CW'(1);
          job_id_next        = ID_W'(best_id) + ID_W'(1);
          finish_tick_next   = fin;
          turnaround_next    = SPAN_W'(fin - TICK_W'(best_arr));
          wait_ticks_next    = SPAN_W'(now - TICK_W'(best_arr));
          last_result_next   = (emitted + CW'(1)) == count;
          state_next         = ST_OUT;
        end else begin
          // nothing has arrived: jump to the earliest pending arrival and rescan
          now_next       = TICK_W'(min_arr);
          idx_next       = '0;
          min_seen_next  = 1'b0;
          state_next     = ST_READ;
        end
      end

      ST_OUT: begin
        if (!out_stall) begin
          idx_next       = '0;
          have_best_next = 1'b0;
          min_seen_next  = 1'b0;
          if (last_result) begin
            count_next   = '0;
            emitted_next = '0;
            done_next    = '0;
            now_next     = '0;
            state_next   = ST_IDLE;
          end else begin
            state_next   = ST_READ;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // loading and emitting never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && !in_stall))
    else $error("load and result channels active together");

  // never more jobs retired than stored
  a_done_bound: assert property (@(posedge clk) disable iff (rst)
    ($countones(done) <= int'(count)) && (emitted <= count))
    else $error("retired jobs exceed stored jobs");

  // final result of a set leaves the block empty
  a_set_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last_result) |=>
      (count == '0) && (done == '0) && (now == '0) && !in_stall)
    else $error("set not cleared after last result");

  // scan pointer stays inside the stored jobs
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL || state == ST_CMP) |-> (CW'(idx) < count))
    else $error("scan index beyond job count");
`endif

endmodule
